[design/lcg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_pkg: shared types and constants
// Operation codes, generator constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lcg_pkg;
  localparam int MAX_BYTES = 64;
  localparam logic [47:0] LCG_MULT = 48'h0005DEECE66D;
  localparam logic [47:0] LCG_INC  = 48'h00000000000B;

  typedef enum logic [3:0] {
    OP_RESEED = 4'd0, OP_RAW = 4'd1, OP_INT = 4'd2, OP_BOUNDED = 4'd3,
    OP_LONG = 4'd4, OP_BOOL = 4'd5, OP_FLOAT = 4'd6, OP_DOUBLE = 4'd7,
    OP_BYTES = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_EVAL, ST_DIV, ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new input transaction
    logic mul_lo;     // capture both partial products of the state update
    logic mul_hi;     // state update from the registered partial products
    logic eval;       // form the result from the new state
    logic div_start;  // begin the modulo unit
    logic div_step;   // one restoring division step
    logic rej_eval;   // apply the overflow rejection test
    logic out_take;   // result transaction completed
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;    // bounded int with a non power of two bound
    logic need_more;   // operation needs another draw
    logic div_done;
    logic rejected;
    logic out_valid;
    logic valid_op;
    logic is_reseed;
    logic empty_run;   // bytes op with zero count
  } dp_sts_t;
endpackage
`default_nettype wire

[design/lcg48_random_generator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_random_generator_core: 48-bit linear congruential random generator
// Produces integer, fraction and byte results from a 48-bit LCG state.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Contents
// in       input      in_valid / in_ready   op, seed, bit count, bound, count
// out      output     out_valid / out_ready value, last_of_run
//
// Each draw passes through a registered split 48x35 multiply, the state update
// and result formation, then waits in the result state; a new transaction is
// accepted only once the previous one's last result has been taken. A non
// power of two bound adds a restoring division to each draw, and each rejected
// draw repeats the draw and the division. Reseed goes straight to the result
// state. Reset is synchronous and restores the scrambled zero seed. A stalled
// result holds the sequence until taken.
// ----------------------------------------------------------------------------
module lcg48_random_generator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_op,
  input  wire logic [63:0] in_seed_value,
  input  wire logic [5:0]  in_bit_count,
  input  wire logic [30:0] in_bound,
  input  wire logic [6:0]  in_byte_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_value,
  output logic             out_last_of_run
);
  import lcg_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences every draw; the datapath holds the generator state and results.
  lcg_controller u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_ready, .cmd, .sts
  );

  lcg_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_op, .in_seed_value, .in_bit_count,
    .in_bound, .in_byte_count, .out_value, .out_last_of_run
  );

  assign out_valid = sts.out_valid;
endmodule
`default_nettype wire

[design/lcg_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_datapath: state register, split multiplier, result formation, modulo unit
// Holds the 48-bit generator state and forms every result value.
// ----------------------------------------------------------------------------
module lcg_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lcg_pkg::dp_cmd_t cmd,
  output lcg_pkg::dp_sts_t     sts,
  input  wire logic [3:0]      in_op,
  input  wire logic [63:0]     in_seed_value,
  input  wire logic [5:0]      in_bit_count,
  input  wire logic [30:0]     in_bound,
  input  wire logic [6:0]      in_byte_count,
  output logic [63:0]          out_value,
  output logic                 out_last_of_run
);
  import lcg_pkg::*;

  logic [47:0] state_r, state_nxt;
  logic [3:0]  op_r;
  logic [5:0]  bits_r;
  logic [30:0] bound_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        phase_r;
  logic [47:0] plo_r;
  logic [47:0] phi_r;
  logic [63:0] acc_r, acc_nxt;
  logic        out_valid_r;
  logic        last_r;
  logic [30:0] draw31_r;
  logic [31:0] rem_r;
  logic [30:0] quo_src_r;
  logic [4:0]  dcnt_r;
  logic        div_busy_r;

  // Partial products: state * low 24 bits and low 24 state bits * high 11 bits of multiplier.
  logic [47:0] plo_c, phi_c;
  assign plo_c = 48'(state_r * LCG_MULT[23:0]);
  assign phi_c = 48'(state_r[23:0] * LCG_MULT[34:24]);
  assign state_nxt = 48'(plo_r + {phi_r[23:0], 24'd0} + LCG_INC);

  // Draw from the new state.
  logic [5:0]  k;
  logic [31:0] top32;
  logic [63:0] drawk;
  logic        pow2;
  always_comb begin
    k = (bits_r > 6'd32) ? 6'd32 : bits_r;
    top32 = state_r[47:16];
    if (k == 6'd0) drawk = 64'd0;
    else begin
      drawk = {32'd0, top32 >> (6'd32 - k)};
      if (k == 6'd32) drawk = {{32{top32[31]}}, top32};
    end
    pow2 = ((bound_r & (bound_r - 31'd1)) == 31'd0);
  end

  logic [31:0] rem_sh;
  logic [31:0] rem_try;
  always_comb begin
    rem_sh = {rem_r[30:0], quo_src_r[30]};
    rem_try = rem_sh - {1'b0, bound_r};
  end
  logic [31:0] chk;
  assign chk = 32'({1'b0, draw31_r} - rem_r + {1'b0, bound_r} - 32'd1);

  logic [5:0] eff_bits;
  logic [6:0] cnt_sat;
  always_comb begin
    eff_bits = in_bit_count;
    case (in_op)
      OP_INT, OP_LONG: eff_bits = 6'd32;
      OP_BOUNDED:      eff_bits = 6'd31;
      OP_BOOL:         eff_bits = 6'd1;
      OP_FLOAT:        eff_bits = 6'd24;
      OP_DOUBLE:       eff_bits = 6'd26;
      OP_BYTES:        eff_bits = 6'd8;
      default:         eff_bits = in_bit_count;
    endcase
    cnt_sat = (in_byte_count > 7'(MAX_BYTES)) ? 7'(MAX_BYTES) : in_byte_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LCG_MULT;
      out_valid_r <= 1'b0;
      div_busy_r <= 1'b0;
    end else begin
      if (cmd.out_take) out_valid_r <= 1'b0;
      if (cmd.load) begin
        op_r <= in_op; bits_r <= eff_bits;
        bound_r <= in_bound; cnt_r <= cnt_sat; phase_r <= 1'b0; acc_r <= 64'd0;
        if (in_op == OP_RESEED) begin
          state_r <= in_seed_value[47:0] ^ LCG_MULT;
          out_value <= 64'd0; last_r <= 1'b1; out_valid_r <= 1'b1;
        end
      end
      if (cmd.mul_lo) begin
        plo_r <= plo_c; phi_r <= phi_c;
      end
      if (cmd.mul_hi) state_r <= state_nxt;
      if (cmd.eval) begin
        case (op_r)
          OP_RAW, OP_INT, OP_FLOAT: begin
            out_value <= drawk; last_r <= 1'b1; out_valid_r <= 1'b1;
          end
          OP_BOOL: begin
            out_value <= drawk; last_r <= 1'b1; out_valid_r <= 1'b1;
          end
          OP_BOUNDED: begin
            draw31_r <= drawk[30:0];
            if (bound_r == 31'd0) begin
              out_value <= 64'd0; last_r <= 1'b1; out_valid_r <= 1'b1;
            end else if (pow2) begin
              out_value <= 64'(({33'd0, drawk[30:0]} * {33'd0, bound_r}) >> 31);
              last_r <= 1'b1; out_valid_r <= 1'b1;
            end
          end
          OP_LONG: begin
            if (!phase_r) begin
              acc_r <= {drawk[31:0], 32'd0}; phase_r <= 1'b1;
            end else begin
              out_value <= acc_r + drawk; last_r <= 1'b1; out_valid_r <= 1'b1;
            end
          end
          OP_DOUBLE: begin
            if (!phase_r) begin
              acc_r <= {drawk[36:0], 27'd0}; phase_r <= 1'b1; bits_r <= 6'd27;
            end else begin
              out_value <= acc_r + drawk; last_r <= 1'b1; out_valid_r <= 1'b1;
            end
          end
          OP_BYTES: begin
            out_value <= {56'd0, drawk[7:0]};
            last_r <= (cnt_r == 7'd1); out_valid_r <= 1'b1;
            cnt_r <= cnt_r - 7'd1;
          end
          default: ;
        endcase
      end
      // The dividend is the draw being formed in this same cycle.
      if (cmd.div_start) begin
        rem_r <= 32'd0; quo_src_r <= drawk[30:0]; dcnt_r <= 5'd0; div_busy_r <= 1'b1;
      end
      if (cmd.div_step && div_busy_r) begin
        rem_r <= rem_try[31] ? rem_sh : rem_try;
        quo_src_r <= {quo_src_r[29:0], 1'b0};
        dcnt_r <= dcnt_r + 5'd1;
        if (dcnt_r == 5'd30) div_busy_r <= 1'b0;
      end
      if (cmd.rej_eval && !chk[31]) begin
        out_value <= {32'd0, rem_r}; last_r <= 1'b1; out_valid_r <= 1'b1;
      end
    end
  end

  assign out_last_of_run = last_r;
  assign cnt_nxt = cnt_r;

  always_comb begin
    sts.need_div  = (op_r == OP_BOUNDED) && (bound_r != 31'd0) && !pow2;
    // Long and double need the second draw only while no result is pending.
    sts.need_more = ((op_r == OP_LONG || op_r == OP_DOUBLE) && phase_r && !out_valid_r) ||
                    ((op_r == OP_BYTES) && (cnt_nxt != 7'd0));
    sts.div_done  = !div_busy_r;
    sts.rejected  = chk[31];
    sts.out_valid = out_valid_r;
    sts.valid_op  = (in_op <= 4'(OP_BYTES));
    sts.is_reseed = (in_op == OP_RESEED);
    sts.empty_run = (in_op == OP_BYTES) && (in_byte_count == 7'd0);
  end
endmodule
`default_nettype wire

[design/lcg_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_controller: sequencing state machine
// Steps each draw through multiply, update, evaluation and optional modulo.
// ----------------------------------------------------------------------------
module lcg_controller (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             out_ready,
  output lcg_pkg::dp_cmd_t      cmd,
  input  wire lcg_pkg::dp_sts_t sts
);
  import lcg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  logic accept, take;
  assign accept = in_valid && in_ready;
  assign take   = sts.out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && sts.valid_op && !sts.empty_run)
          state_nxt = sts.is_reseed ? ST_OUT : ST_MUL;
      end
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = sts.need_div ? ST_DIV : ST_OUT;
      ST_DIV:  if (sts.div_done) state_nxt = sts.rejected ? ST_MUL : ST_OUT;
      ST_OUT: begin
        if (!sts.out_valid) state_nxt = sts.need_more ? ST_MUL : ST_IDLE;
        else if (take) state_nxt = sts.need_more ? ST_MUL : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic div_started_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_started_r <= 1'b0;
    else if (state_r == ST_EVAL) div_started_r <= 1'b0;
    else if (state_r == ST_DIV) div_started_r <= 1'b1;
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE) && !sts.out_valid;
    cmd = '0;
    cmd.load = accept;
    cmd.out_take = take;
    case (state_r)
      ST_MUL:  cmd.mul_lo = 1'b1;
      ST_ADD:  cmd.mul_hi = 1'b1;
      ST_EVAL: begin
        cmd.eval = 1'b1;
        cmd.div_start = sts.need_div;
      end
      ST_DIV: begin
        cmd.div_step = div_started_r;
        cmd.rej_eval = sts.div_done && div_started_r;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lcg48_random_generator_core
// Drives directed and random operations through the input channel, keeps an
// own copy of the 48-bit generator state to predict every result, and checks
// each result transaction in order under several idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  import lcg_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_op;
  logic [63:0] in_seed_value;
  logic [5:0]  in_bit_count;
  logic [30:0] in_bound;
  logic [6:0]  in_byte_count;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_value;
  logic        out_last_of_run;

  // Expected results, oldest first: value and last-of-run flag.
  logic [63:0] exp_value_q[$];
  logic        exp_last_q[$];

  // Predicted generator state.
  logic [47:0] seed_state;

  int mismatches;
  int send_idle_pct;   // chance in percent that the sender idles a cycle
  int recv_stall_pct;  // chance in percent that the receiver stalls a cycle

  lcg48_random_generator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_seed_value(in_seed_value), .in_bit_count(in_bit_count),
    .in_bound(in_bound), .in_byte_count(in_byte_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the predicted state and return its top k bits, sign-extended
  // from bit 31 as a 64-bit value. A width of zero still advances the state.
  function automatic logic [63:0] next_draw(input int k);
    logic [95:0] prod;
    logic [31:0] top;
    prod = seed_state * LCG_MULT + LCG_INC;
    seed_state = prod[47:0];
    if (k == 0) return 64'd0;
    if (k > 32) k = 32;
    top = 32'(seed_state >> (48 - k));
    return {{32{top[31]}}, top};
  endfunction

  // Compute the expected results of one transaction and queue them.
  task automatic predict_results(input logic [3:0] op, input logic [63:0] seed,
                                 input logic [5:0] bits, input logic [30:0] bnd,
                                 input logic [6:0] cnt);
    logic [63:0] v, a, b;
    logic [31:0] d, r, n;
    int count;
    case (op)
      OP_RESEED: begin
        seed_state = seed[47:0] ^ LCG_MULT;
        v = 64'd0;
      end
      OP_RAW: v = next_draw(bits);
      OP_INT: v = next_draw(32);
      OP_BOUNDED: begin
        n = {1'b0, bnd};
        if (n == 0) begin
          void'(next_draw(31));
          v = 64'd0;
        end else if ((n & (n - 1)) == 0) begin
          v = (next_draw(31) * 64'(n)) >> 31;
        end else begin
          // Redraw while the 32-bit sum overflows into the sign bit.
          do begin
            d = 32'(next_draw(31));
            r = d % n;
          end while (((d - r + (n - 1)) & 32'h8000_0000) != 0);
          v = 64'(r);
        end
      end
      OP_LONG: begin
        a = next_draw(32);
        b = next_draw(32);
        v = (a << 32) + b;
      end
      OP_BOOL: v = (next_draw(1) != 0) ? 64'd1 : 64'd0;
      OP_FLOAT: v = next_draw(24);
      OP_DOUBLE: begin
        a = next_draw(26);
        b = next_draw(27);
        v = (a << 27) + b;
      end
      OP_BYTES: begin
        count = (cnt > MAX_BYTES) ? MAX_BYTES : int'(cnt);
        for (int i = 0; i < count; i++) begin
          exp_value_q.push_back(next_draw(8) & 64'hFF);
          exp_last_q.push_back(i + 1 == count);
        end
        return;
      end
      default: return;  // undefined operations are ignored
    endcase
    exp_value_q.push_back(v);
    exp_last_q.push_back(1'b1);
  endtask

  // Offer one transaction, idling first at random, and wait for acceptance.
  // Ready is sampled on the falling clock edge, where it is stable.
  task automatic send_item(input logic [3:0] op, input logic [63:0] seed,
                           input logic [5:0] bits, input logic [30:0] bnd,
                           input logic [6:0] cnt);
    logic ready_seen;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_seed_value <= seed;
    in_bit_count  <= bits;
    in_bound      <= bnd;
    in_byte_count <= cnt;
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
    // Accepted at this edge; the prediction follows the acceptance order.
    predict_results(op, seed, bits, bnd, cnt);
  endtask

  // Drop valid after the last transaction of a pass.
  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Each completed result transaction is checked on the falling clock edge ahead of
  // the rising edge that completes it, while the handshake signals are stable.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_value_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result value=%h last=%b", out_value,
                   out_last_of_run);
      end else begin
        if (out_value !== exp_value_q[0] || out_last_of_run !== exp_last_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected value=%h last=%b, got value=%h last=%b",
                     exp_value_q[0], exp_last_q[0], out_value, out_last_of_run);
        end
        void'(exp_value_q.pop_front());
        void'(exp_last_q.pop_front());
      end
    end
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // A random transaction of any kind, including a few undefined operations.
  task automatic send_random_item();
    logic [3:0] op;
    logic [30:0] bnd;
    op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    case ($urandom_range(3))
      0: bnd = 31'd1 << $urandom_range(30);
      1: bnd = 31'($urandom_range(100));
      default: bnd = 31'($urandom());
    endcase
    // Byte runs are mostly short so the run stays quick.
    send_item(op, rand64(), 6'($urandom()), bnd,
              ($urandom_range(9) == 0) ? 7'($urandom()) : 7'($urandom_range(8)));
  endtask

  task automatic wait_drained();
    while (exp_value_q.size() != 0) @(posedge clk);
  endtask

  // Directed pass: every operation plus the special cases of each field.
  task automatic test_directed();
    send_item(OP_INT, 64'd0, 6'd0, 31'd0, 7'd0);  // first draw from the reset seed
    send_item(OP_RESEED, 64'h8000_0000_0000_0000, 6'd0, 31'd0, 7'd0);
    send_item(OP_RESEED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 31'd0, 7'd0);
    send_item(OP_RESEED, 64'd42, 6'd0, 31'd0, 7'd0);
    send_item(OP_RAW, 64'd0, 6'd0, 31'd0, 7'd0);    // zero width still draws
    send_item(OP_RAW, 64'd0, 6'd1, 31'd0, 7'd0);
    send_item(OP_RAW, 64'd0, 6'd32, 31'd0, 7'd0);
    send_item(OP_RAW, 64'd0, 6'd63, 31'd0, 7'd0);   // clamps to 32
    send_item(OP_BOUNDED, 64'd0, 6'd0, 31'd0, 7'd0);
    send_item(OP_BOUNDED, 64'd0, 6'd0, 31'd1, 7'd0);
    send_item(OP_BOUNDED, 64'd0, 6'd0, 31'h4000_0000, 7'd0);
    send_item(OP_BOUNDED, 64'd0, 6'd0, 31'h7FFF_FFFF, 7'd0);
    send_item(OP_BOUNDED, 64'd0, 6'd0, 31'h4000_0001, 7'd0);  // rejects often
    send_item(OP_BOUNDED, 64'd0, 6'd0, 31'd6, 7'd0);
    send_item(OP_LONG, 64'd0, 6'd0, 31'd0, 7'd0);
    send_item(OP_BOOL, 64'd0, 6'd0, 31'd0, 7'd0);
    send_item(OP_FLOAT, 64'd0, 6'd0, 31'd0, 7'd0);
    send_item(OP_DOUBLE, 64'd0, 6'd0, 31'd0, 7'd0);
    send_item(OP_BYTES, 64'd0, 6'd0, 31'd0, 7'd0);  // empty run
    send_item(OP_BYTES, 64'd0, 6'd0, 31'd0, 7'd1);
    send_item(OP_BYTES, 64'd0, 6'd0, 31'd0, 7'd64);
    send_item(OP_BYTES, 64'd0, 6'd0, 31'd0, 7'd127); // saturates
    send_item(4'd9, 64'd0, 6'd0, 31'd0, 7'd3);
    send_item(4'd15, 64'd0, 6'd0, 31'd0, 7'd3);
    send_item(OP_INT, 64'd0, 6'd0, 31'd0, 7'd0);
    release_input();
  endtask

  // Random pass under one idling pattern.
  task automatic test_random(input int items, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) send_random_item();
    release_input();
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_RESEED;
    in_seed_value  = 64'd0;
    in_bit_count   = 6'd0;
    in_bound       = 31'd0;
    in_byte_count  = 7'd0;
    out_ready      = 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    seed_state     = LCG_MULT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_drained();
    test_random(90, 0, 0);
    test_random(85, 72, 0);
    test_random(85, 0, 72);
    test_random(90, 25, 25);
    repeat (200) @(posedge clk);

    if (mismatches == 0 && exp_value_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Timeout well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
